/* hw/rtl/spd_pkg.sv */
// Shared types and constants of the sensor packet deframer.
`default_nettype none
package spd_pkg;

    // Packet store depth default
    localparam int PACKET_STORE_BYTES = 80;

    // Start bytes
    localparam logic [7:0] START_ARM  = 8'hCB;
    localparam logic [7:0] START_DAV  = 8'hD3;
    localparam logic [7:0] START_ROT  = 8'hCC;
    localparam logic [7:0] START_ECHO = 8'hC4;

    // Packet lengths in bytes
    localparam logic [6:0] LEN_ARM  = 7'd43;
    localparam logic [6:0] LEN_DAV  = 7'd43;
    localparam logic [6:0] LEN_ROT  = 7'd79;
    localparam logic [6:0] LEN_ECHO = 7'd8;

    // Packet kinds
    localparam logic [1:0] KIND_ARM  = 2'd0;
    localparam logic [1:0] KIND_DAV  = 2'd1;
    localparam logic [1:0] KIND_ROT  = 2'd2;
    localparam logic [1:0] KIND_ECHO = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_DATA = 2'd0;
    localparam logic [1:0] STATUS_ECHO = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    // Expected mode codes
    localparam logic [1:0] MODE_ARM = 2'd0;
    localparam logic [1:0] MODE_DAV = 2'd1;
    localparam logic [1:0] MODE_ROT = 2'd2;

    // Index of the final (timer) word
    localparam logic [4:0] LAST_WORD_SHORT = 5'd9;
    localparam logic [4:0] LAST_WORD_LONG  = 5'd18;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;       // input byte accepted this cycle
        logic rd_issue;   // issue a packet store read, advance read address
        logic shift;      // shift read data into the word register
        logic next_word;  // advance to the next payload word
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pkt_end;    // current input byte completes a packet
        logic single;     // that packet gives one echo or error result
        logic last;       // result being presented is the final one
    } dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/spd_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/spd_ctrl.sv */
// Controller state machine of the sensor packet deframer.
`default_nettype none
module spd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire spd_pkg::dp_status_t sts,
    output spd_pkg::ctrl_cmd_t     cmd
);

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    localparam logic [2:0] BYTES_PER_WORD = 3'd4;

    logic [1:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.take      = 1'b0;
        cmd.rd_issue  = 1'b0;
        cmd.shift     = 1'b0;
        cmd.next_word = 1'b0;
        case (state_reg)
            S_RUN:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && sts.pkt_end)
                begin
                    cnt_next   = 3'd0;
                    state_next = sts.single ? S_OUT : S_READ;
                end
            end
            S_READ:
            begin
                // four reads issued, each read's data shifted in on the following cycle
                cmd.rd_issue = (cnt_reg != BYTES_PER_WORD);
                cmd.shift    = (cnt_reg != 3'd0);
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == BYTES_PER_WORD)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cnt_next = 3'd0;
                    if (sts.last)
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        cmd.next_word = 1'b1;
                        state_next    = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/spd_dp.sv */
// Datapath of the sensor packet deframer: framing, checksum, store and word assembly.
`default_nettype none
module spd_dp #(
    parameter int PACKET_STORE_BYTES = spd_pkg::PACKET_STORE_BYTES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                expected_mode_we,
    input  wire logic [1:0]          expected_mode,
    input  wire logic [7:0]          rx_byte,
    input  wire spd_pkg::ctrl_cmd_t  cmd,
    output spd_pkg::dp_status_t      sts,
    output logic      [1:0]          status,
    output logic      [1:0]          packet_kind,
    output logic      [4:0]          word_index,
    output logic      [31:0]         word_value,
    output logic                     mode_mismatch,
    output logic                     last
);

    localparam int AW = $clog2(PACKET_STORE_BYTES);

    // Control state
    logic [1:0]    mode_reg;
    logic          hunting_reg;
    logic [1:0]    kind_reg;
    logic [6:0]    bytes_expected_reg;
    logic [6:0]    bytes_seen_reg;
    logic [15:0]   running_sum_reg;
    logic [7:0]    prev_byte_reg;
    logic [AW-1:0] rd_addr_reg;

    // Result registers
    logic [1:0]    status_reg;
    logic [4:0]    word_idx_reg;
    logic [31:0]   word_reg;
    logic          mism_reg;
    logic          single_reg;

    logic          is_start;
    logic [1:0]    start_kind;
    logic [6:0]    start_len;
    logic [6:0]    seen_inc;
    logic          sum_ok;
    logic          mism;
    logic [4:0]    last_word;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_data;

    always_comb
    begin
        is_start   = 1'b1;
        start_kind = spd_pkg::KIND_ARM;
        start_len  = spd_pkg::LEN_ARM;
        case (rx_byte)
            spd_pkg::START_ARM:
            begin
                start_kind = spd_pkg::KIND_ARM;
                start_len  = spd_pkg::LEN_ARM;
            end
            spd_pkg::START_DAV:
            begin
                start_kind = spd_pkg::KIND_DAV;
                start_len  = spd_pkg::LEN_DAV;
            end
            spd_pkg::START_ROT:
            begin
                start_kind = spd_pkg::KIND_ROT;
                start_len  = spd_pkg::LEN_ROT;
            end
            spd_pkg::START_ECHO:
            begin
                start_kind = spd_pkg::KIND_ECHO;
                start_len  = spd_pkg::LEN_ECHO;
            end
            default:
            begin
                is_start = 1'b0;
            end
        endcase
    end

    // The trailing sum is the previous byte and the current one.
    assign seen_inc = bytes_seen_reg + 7'd1;
    assign sum_ok   = (running_sum_reg == {prev_byte_reg, rx_byte});

    always_comb
    begin
        case (kind_reg)
            spd_pkg::KIND_ROT: mism = (mode_reg != spd_pkg::MODE_ROT);
            spd_pkg::KIND_ARM: mism = (mode_reg == spd_pkg::MODE_ROT);
            default:           mism = (mode_reg != spd_pkg::MODE_DAV);
        endcase
    end

    assign last_word = (kind_reg == spd_pkg::KIND_ROT) ? spd_pkg::LAST_WORD_LONG
                                                       : spd_pkg::LAST_WORD_SHORT;

    assign sts.pkt_end = !hunting_reg && (seen_inc == bytes_expected_reg);
    assign sts.single  = !sum_ok || (kind_reg == spd_pkg::KIND_ECHO);
    assign sts.last    = single_reg || (word_idx_reg == last_word);

    assign wr_en   = cmd.take && (hunting_reg ? is_start
                                  : (32'(bytes_seen_reg) < 32'(PACKET_STORE_BYTES)));
    assign wr_addr = hunting_reg ? '0 : AW'(bytes_seen_reg);

    spd_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= spd_pkg::MODE_ARM;
            hunting_reg        <= 1'b1;
            kind_reg           <= spd_pkg::KIND_ARM;
            bytes_expected_reg <= 7'd1;
            bytes_seen_reg     <= 7'd0;
            running_sum_reg    <= 16'd0;
            rd_addr_reg        <= AW'(1);
        end
        else
        begin
            if (expected_mode_we)
            begin
                mode_reg <= expected_mode;
            end
            if (cmd.take)
            begin
                if (hunting_reg)
                begin
                    if (is_start)
                    begin
                        hunting_reg        <= 1'b0;
                        kind_reg           <= start_kind;
                        bytes_expected_reg <= start_len;
                        bytes_seen_reg     <= 7'd1;
                        running_sum_reg    <= {8'd0, rx_byte};
                    end
                end
                else if (sts.pkt_end)
                begin
                    hunting_reg        <= 1'b1;
                    bytes_expected_reg <= 7'd1;
                    bytes_seen_reg     <= 7'd0;
                    running_sum_reg    <= 16'd0;
                    rd_addr_reg        <= AW'(1);
                end
                else
                begin
                    bytes_seen_reg <= seen_inc;
                    if (({1'b0, bytes_seen_reg} + 8'd2) < {1'b0, bytes_expected_reg})
                    begin
                        running_sum_reg <= running_sum_reg + {8'd0, rx_byte};
                    end
                end
            end
            else if (cmd.rd_issue)
            begin
                rd_addr_reg <= rd_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && !hunting_reg)
        begin
            prev_byte_reg <= rx_byte;
        end
        if (cmd.take && sts.pkt_end)
        begin
            word_idx_reg <= 5'd0;
            word_reg     <= 32'd0;
            single_reg   <= sts.single;
            if (!sum_ok)
            begin
                status_reg <= spd_pkg::STATUS_ERR;
                mism_reg   <= 1'b0;
            end
            else if (kind_reg == spd_pkg::KIND_ECHO)
            begin
                status_reg <= spd_pkg::STATUS_ECHO;
                mism_reg   <= 1'b0;
            end
            else
            begin
                status_reg <= spd_pkg::STATUS_DATA;
                mism_reg   <= mism;
            end
        end
        else
        begin
            if (cmd.shift)
            begin
                word_reg <= {word_reg[23:0], rd_data};
            end
            if (cmd.next_word)
            begin
                word_idx_reg <= word_idx_reg + 5'd1;
            end
        end
    end

    assign status        = status_reg;
    assign packet_kind   = kind_reg;
    assign word_index    = word_idx_reg;
    assign word_value    = word_reg;
    assign mode_mismatch = mism_reg;
    assign last          = sts.last;

endmodule
`default_nettype wire

/* hw/rtl/sensor_packet_deframer.sv */
// Top level of the sensor packet deframer.
// Input: one byte per cycle while collecting a packet; a byte that does not finish a packet
// gives no result. After the final byte, each payload word takes four store reads through the
// registered store port plus assembly, then waits on out_ready. Echo and checksum error
// results appear the cycle after the final byte. No byte is taken until the last result of
// a packet is delivered. Reset (rst_n low, asynchronous) returns the block to hunting with
// expected_mode 0; the packet store is not cleared.
`default_nettype none
module sensor_packet_deframer #(
    parameter int PACKET_STORE_BYTES = spd_pkg::PACKET_STORE_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write
    input  wire logic        expected_mode_we,
    input  wire logic [1:0]  expected_mode,
    // received bytes
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // result words
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [1:0]  status,
    output logic      [1:0]  packet_kind,
    output logic      [4:0]  word_index,
    output logic      [31:0] word_value,
    output logic             mode_mismatch,
    output logic             last
);

    // Controller sequences accept, store reads and result hand-off; the datapath
    // holds framing state, the running checksum and the packet store.
    spd_pkg::ctrl_cmd_t  cmd;
    spd_pkg::dp_status_t sts;

    spd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Drop unknown bytes while hunting, check the additive sum at the packet end,
    // and assemble big-endian words from the store for good data packets.
    spd_dp #(
        .PACKET_STORE_BYTES (PACKET_STORE_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .expected_mode_we (expected_mode_we),
        .expected_mode    (expected_mode),
        .rx_byte          (rx_byte),
        .cmd              (cmd),
        .sts              (sts),
        .status           (status),
        .packet_kind      (packet_kind),
        .word_index       (word_index),
        .word_value       (word_value),
        .mode_mismatch    (mode_mismatch),
        .last             (last)
    );

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the sensor packet deframer: byte stimulus, word scoreboard.
`timescale 1ns / 1ps
module testbench;
    import spd_pkg::*;

    localparam int GAP_MAX       = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 100;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_BYTES   = 8;
    localparam int TIMEOUT_NS    = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [4:0]  idx;
        logic [31:0] value;
        logic        mism;
        logic        last;
    } word_result_t;

    // Deframer predictor plus the queue of result words it still owes.
    class deframe_checker;
        logic [1:0]   mode;
        bit           hunting;
        logic [1:0]   kind;
        int unsigned  need;
        int unsigned  seen;
        logic [15:0]  sum;
        logic [7:0]   store [PACKET_STORE_BYTES];
        word_result_t words_due[$];
        int           errors;
        int           words_checked;
        int           data_packets;
        int           echoes;
        int           bad_sums;

        function new();
            mode          = MODE_ARM;
            hunting       = 1'b1;
            kind          = KIND_ARM;
            need          = 1;
            seen          = 0;
            sum           = '0;
            errors        = 0;
            words_checked = 0;
            data_packets  = 0;
            echoes        = 0;
            bad_sums      = 0;
        endfunction

        function void set_mode(logic [1:0] m);
            mode = m;
        endfunction

        function void owe(logic [1:0] st, logic [1:0] k, logic [4:0] i, logic [31:0] v,
                          logic mm, logic lst);
            word_result_t w;
            w.status = st;
            w.kind   = k;
            w.idx    = i;
            w.value  = v;
            w.mism   = mm;
            w.last   = lst;
            words_due.push_back(w);
        endfunction

        // Advance the predictor by one accepted byte.
        function void take_byte(logic [7:0] b);
            logic [15:0] sent;
            logic        mism;
            logic [4:0]  top;
            if (hunting)
            begin
                case (b)
                    START_ARM:
                    begin
                        kind = KIND_ARM;
                        need = LEN_ARM;
                    end
                    START_DAV:
                    begin
                        kind = KIND_DAV;
                        need = LEN_DAV;
                    end
                    START_ROT:
                    begin
                        kind = KIND_ROT;
                        need = LEN_ROT;
                    end
                    START_ECHO:
                    begin
                        kind = KIND_ECHO;
                        need = LEN_ECHO;
                    end
                    default:
                    begin
                        return;
                    end
                endcase
                store[0] = b;
                seen     = 1;
                sum      = {8'h00, b};
                hunting  = 1'b0;
                return;
            end
            store[seen] = b;
            // the two trailing bytes carry the sum and stay out of it
            if (seen + 2 < need)
                sum = sum + {8'h00, b};
            seen++;
            if (seen < need)
                return;
            sent    = {store[need - 2], store[need - 1]};
            hunting = 1'b1;
            need    = 1;
            seen    = 0;
            if (sum != sent)
            begin
                bad_sums++;
                owe(STATUS_ERR, kind, 5'd0, 32'd0, 1'b0, 1'b1);
            end
            else if (kind == KIND_ECHO)
            begin
                echoes++;
                owe(STATUS_ECHO, KIND_ECHO, 5'd0, 32'd0, 1'b0, 1'b1);
            end
            else
            begin
                top = (kind == KIND_ROT) ? LAST_WORD_LONG : LAST_WORD_SHORT;
                case (kind)
                    KIND_ROT: mism = (mode != MODE_ROT);
                    KIND_ARM: mism = (mode == MODE_ROT);
                    default:  mism = (mode != MODE_DAV);
                endcase
                data_packets++;
                // payload words start right after the start byte; the timer is the last
                for (int i = 0; i <= top; i++)
                    owe(STATUS_DATA, kind, i[4:0],
                        {store[1 + 4 * i], store[2 + 4 * i], store[3 + 4 * i],
                         store[4 + 4 * i]},
                        mism, i == top);
            end
        endfunction

        function void compare(string field, logic [31:0] want_v, logic [31:0] seen_v);
            if (seen_v !== want_v)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, field, want_v, seen_v);
            end
        endfunction

        // Match one delivered word against the oldest owed word.
        function void check_word(word_result_t got_w);
            word_result_t want;
            words_checked++;
            if (words_due.size() == 0)
            begin
                errors++;
                $display({"%0t: word with nothing expected: expected none, ",
                          "actual status %0d kind %0d index %0d value %h"},
                         $time, got_w.status, got_w.kind, got_w.idx, got_w.value);
                return;
            end
            want = words_due.pop_front();
            compare("status", 32'(want.status), 32'(got_w.status));
            compare("packet_kind", 32'(want.kind), 32'(got_w.kind));
            compare("word_index", 32'(want.idx), 32'(got_w.idx));
            compare("word_value", want.value, got_w.value);
            compare("mode_mismatch", 32'(want.mism), 32'(got_w.mism));
            compare("last", 32'(want.last), 32'(got_w.last));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        expected_mode_we;
    logic [1:0]  expected_mode;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [1:0]  packet_kind;
    logic [4:0]  word_index;
    logic [31:0] word_value;
    logic        mode_mismatch;
    logic        last;

    deframe_checker board;
    logic [7:0]     frame[$];
    int             bytes_sent = 0;
    bit             send_calm  = 1'b0;

    sensor_packet_deframer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .expected_mode_we (expected_mode_we),
        .expected_mode    (expected_mode),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .packet_kind      (packet_kind),
        .word_index       (word_index),
        .word_value       (word_value),
        .mode_mismatch    (mode_mismatch),
        .last             (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one byte after a random gap; hold it until taken. Enter and leave at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (bytes_sent % 24 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic int frame_len(input logic [1:0] k);
        case (k)
            KIND_ARM: return int'(LEN_ARM);
            KIND_DAV: return int'(LEN_DAV);
            KIND_ROT: return int'(LEN_ROT);
            default:  return int'(LEN_ECHO);
        endcase
    endfunction

    // Load the frame with a start byte and n random body bytes.
    function automatic void start_frame(input logic [1:0] k, input int n);
        frame.delete();
        case (k)
            KIND_ARM: frame.push_back(START_ARM);
            KIND_DAV: frame.push_back(START_DAV);
            KIND_ROT: frame.push_back(START_ROT);
            default:  frame.push_back(START_ECHO);
        endcase
        repeat (n)
            frame.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Send the frame; when sealed, append its big-endian sum XORed with flip.
    task automatic send_frame(input logic [15:0] flip, input bit seal);
        logic [15:0] total;
        total = '0;
        foreach (frame[i])
            total = total + {8'h00, frame[i]};
        if (seal)
        begin
            total = total ^ flip;
            frame.push_back(total[15:8]);
            frame.push_back(total[7:0]);
        end
        foreach (frame[i])
            send_byte(frame[i]);
    endtask

    // Mostly well-formed packets; some noise, cut-short packets and bad sums.
    task automatic send_random_packet();
        logic [1:0] k;
        int         pick;
        k    = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick == 1)
        begin
            // cut short: whatever follows lands inside this packet
            start_frame(k, $urandom_range(1, frame_len(k) - 3));
            send_frame(16'h0000, 1'b0);
        end
        else
        begin
            start_frame(k, frame_len(k) - 3);
            send_frame((pick == 2) ? 16'($urandom_range(1, 65535)) : 16'h0000, 1'b1);
        end
    endtask

    // Pad any open packet with random bytes until the block hunts again.
    task automatic finish_packet();
        while (!board.hunting)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Stop offering, wait for every owed word, then let the block settle.
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (board.words_due.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        expected_mode_we <= 1'b1;
        expected_mode    <= m;
        @(negedge clk);
        expected_mode_we <= 1'b0;
        board.set_mode(m);
    endtask

    // Result side: random stalls, calm stretches, one long hold after the first word.
    initial
    begin : result_sink
        int           gap;
        int           taken;
        bit           calm;
        bit           held;
        word_result_t w;
        out_ready = 1'b0;
        taken     = 0;
        calm      = 1'b0;
        held      = 1'b0;
        w         = '0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken % 16 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, GAP_MAX);
            // hold off long enough that the next packet completes and the byte side backs up
            if (!held && taken > 0)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            w.status = status;
            w.kind   = packet_kind;
            w.idx    = word_index;
            w.value  = word_value;
            w.mism   = mode_mismatch;
            w.last   = last;
            board.check_word(w);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int phase_start;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        rx_byte          = 8'h00;
        expected_mode_we = 1'b0;
        expected_mode    = MODE_ARM;
        board            = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int p = 0; p < 4; p++)
        begin
            // change the mode only between packets with nothing in flight
            if (p != 0)
            begin
                finish_packet();
                drain(SETTLE_CYCLES);
            end
            write_mode(2'(p));
            if (p == 0)
            begin
                // junk while hunting: byte extremes and neighbors of start codes
                send_byte(8'h00);
                send_byte(8'hFF);
                send_byte(8'hCA);
                send_byte(8'hC5);
                // good echo; a start code inside the body is plain data
                frame = {START_ECHO, 8'hFF, 8'h00, START_ARM, 8'h7F, 8'h01};
                send_frame(16'h0000, 1'b1);
                // same echo with a sum one bit off
                frame = {START_ECHO, 8'hFF, 8'h00, START_ARM, 8'h7F, 8'h01};
                send_frame(16'h0001, 1'b1);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_packet();
        end
        finish_packet();
        drain(TAIL_CYCLES);

        $display("testbench: %0d bytes in, %0d words checked: %0d data packets, %0d echoes",
                 bytes_sent, board.words_checked, board.data_packets, board.echoes);
        $display("testbench: %0d sum errors, modes 0 to 3, random stalls, one long output hold",
                 board.bad_sums);
        if (board.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("testbench: timeout with %0d words still owed", board.words_due.size());
        $display("testbench: done, errors");
        $finish;
    end

endmodule
